>>> design/ucs_pkg.sv
// Package for the URI component splitter.
// Holds payload structs, result bundle type, phase and error codes, and character classes.
// Depends on nothing.
package ucs_pkg;

  localparam int N_RES       = 3;
  localparam int CNT_W       = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  localparam logic [3:0] PH_SCHEME     = 4'd0;
  localparam logic [3:0] PH_AUTH_SLASH = 4'd1;
  localparam logic [3:0] PH_AUTHORITY  = 4'd2;
  localparam logic [3:0] PH_HOST       = 4'd3;
  localparam logic [3:0] PH_PORT       = 4'd4;
  localparam logic [3:0] PH_PATH       = 4'd5;
  localparam logic [3:0] PH_QUERY      = 4'd6;
  localparam logic [3:0] PH_DONE       = 4'd7;
  localparam logic [3:0] PH_FAILED     = 4'd8;

  localparam logic [2:0] KIND_SCHEME   = 3'd0;
  localparam logic [2:0] KIND_USERINFO = 3'd1;
  localparam logic [2:0] KIND_HOST     = 3'd2;
  localparam logic [2:0] KIND_PORT     = 3'd3;
  localparam logic [2:0] KIND_PATH     = 3'd4;
  localparam logic [2:0] KIND_QUERY    = 3'd5;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_SCHEME     = 4'd1;
  localparam logic [3:0] ERR_AUTHORITY  = 4'd2;
  localparam logic [3:0] ERR_EMPTY_PORT = 4'd3;
  localparam logic [3:0] ERR_PORT       = 4'd4;
  localparam logic [3:0] ERR_PATH       = 4'd5;
  localparam logic [3:0] ERR_QUERY      = 4'd6;
  localparam logic [3:0] ERR_END_SCHEME = 4'd7;
  localparam logic [3:0] ERR_AUTH_START = 4'd8;
  localparam logic [3:0] ERR_TOO_LONG   = 4'd9;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_uri;
  } in_t;

  typedef struct packed {
    logic [2:0]  part_kind;
    logic [11:0] span_start;
    logic [12:0] span_end;
    logic [3:0]  error_code;
    logic        run_last;
    logic        uri_done;
  } out_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] start;
    logic [12:0] stop;
    logic [3:0]  code;
  } span_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic              done;
    span_t [N_RES-1:0] items;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_unres(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_MINUS || c == CH_DOT ||
           c == CH_UNDER || c == CH_TILDE;
  endfunction

  function automatic logic is_subdelim(input logic [7:0] c);
    return c == CH_BANG || c == CH_DOLLAR || c == CH_AMP || c == CH_QUOTE ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_STAR || c == CH_PLUS ||
           c == CH_COMMA || c == CH_SEMI || c == CH_EQUAL;
  endfunction

  function automatic logic is_host(input logic [7:0] c);
    return is_unres(c) || is_subdelim(c) || c == CH_PERCENT;
  endfunction

  function automatic logic is_pchar(input logic [7:0] c);
    return is_host(c) || c == CH_COLON || c == CH_AT;
  endfunction

  function automatic logic [2:0] kind_of_phase(input logic [3:0] ph);
    logic [2:0] k;
    unique case (ph)
      PH_SCHEME:                           k = KIND_SCHEME;
      PH_AUTH_SLASH, PH_AUTHORITY, PH_HOST: k = KIND_HOST;
      PH_PORT:                             k = KIND_PORT;
      PH_QUERY:                            k = KIND_QUERY;
      default:                             k = KIND_PATH;
    endcase
    return k;
  endfunction

  function automatic bundle_t add_span(input bundle_t b, input logic [2:0] k,
                                       input logic [11:0] s, input logic [12:0] e,
                                       input logic [3:0] code);
    bundle_t r;
    r = b;
    if (r.cnt < CNT_W'(N_RES)) begin
      r.items[r.cnt] = '{kind: k, start: s, stop: e, code: code};
      r.cnt = r.cnt + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

>>> design/uri_component_splitter_unit.sv
// A result reaches the output after its character is accepted, by way of the queue write and then
// the output register load, and is held there until it transfers.
// Throughput: one character per cycle while the queue is not full; each result takes one
// output transfer, so a character that yields n results takes n transfers; a 4-bundle queue
// absorbs bursts. Reset: synchronous, active low; clears parser state, queue and output.
// Top level; depends on ucs_pkg, ucs_front, ucs_fifo, ucs_back.
module uri_component_splitter_unit #(
  parameter int MAX_URI_LEN = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  ucs_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output ucs_pkg::out_t out_item
);

  ucs_pkg::bundle_t bnd;
  logic             bnd_push;
  ucs_pkg::bundle_t head;
  logic             q_empty;
  logic             head_take;
  logic             accept;

  assign accept = push && !full;

  ucs_front #(
    .MAX_URI_LEN(MAX_URI_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .bnd      (bnd),
    .bnd_push (bnd_push)
  );

  ucs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (bnd_push),
    .wr_data (bnd),
    .full    (full),
    .pop     (head_take),
    .rd_data (head),
    .empty   (q_empty)
  );

  ucs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .head_take  (head_take),
    .out_item   (out_item),
    .out_empty  (empty),
    .pop        (pop)
  );

endmodule

>>> design/ucs_front.sv
// Front end of the URI component splitter: parser state and span bundle build.
// Classifies one character per cycle while accept is high and emits a bundle of up to three spans.
// Depends on ucs_pkg.
module ucs_front #(
  parameter int MAX_URI_LEN = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  ucs_pkg::in_t     item,
  output ucs_pkg::bundle_t bnd,
  output logic             bnd_push
);

  localparam int POS_W = $clog2(MAX_URI_LEN + 1);

  typedef struct packed {
    ucs_pkg::bundle_t b;
    logic             ok;
  } resolve_t;

  logic [3:0]       ph_r, ph_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ps_r, ps_nxt;
  logic [POS_W-1:0] fcp_r, fcp_nxt;
  logic [1:0]       cc_r, cc_nxt;
  logic             sm_r, sm_nxt;
  logic             pb_r, pb_nxt;

  function automatic resolve_t resolve(input ucs_pkg::bundle_t b, input logic [1:0] cc,
                                       input logic [POS_W-1:0] fcp, input logic pb,
                                       input logic [POS_W-1:0] ps,
                                       input logic [POS_W-1:0] e);
    resolve_t r;
    r.b  = b;
    r.ok = 1'b1;
    if (cc == 2'd0) begin
      r.b = ucs_pkg::add_span(r.b, ucs_pkg::KIND_HOST, 12'(ps), 13'(e), ucs_pkg::ERR_NONE);
    end else if (fcp + POS_W'(1) == e) begin
      r.b  = ucs_pkg::add_span(r.b, ucs_pkg::KIND_PORT, 12'(ps), 13'(e),
                               ucs_pkg::ERR_EMPTY_PORT);
      r.ok = 1'b0;
    end else if (pb) begin
      r.b  = ucs_pkg::add_span(r.b, ucs_pkg::KIND_PORT, 12'(ps), 13'(e), ucs_pkg::ERR_PORT);
      r.ok = 1'b0;
    end else begin
      r.b = ucs_pkg::add_span(r.b, ucs_pkg::KIND_HOST, 12'(ps), 13'(fcp), ucs_pkg::ERR_NONE);
      r.b = ucs_pkg::add_span(r.b, ucs_pkg::KIND_PORT, 12'(fcp + POS_W'(1)), 13'(e),
                              ucs_pkg::ERR_NONE);
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0]       c;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] e;
    logic             auth_go;
    logic             path_go;
    resolve_t         rs;
    ucs_pkg::bundle_t b;

    c       = item.char_code;
    p       = pos_r;
    e       = pos_r + POS_W'(1);
    auth_go = 1'b0;
    path_go = 1'b0;
    rs      = '0;
    b       = '0;
    ph_nxt  = ph_r;
    pos_nxt = pos_r;
    ps_nxt  = ps_r;
    fcp_nxt = fcp_r;
    cc_nxt  = cc_r;
    sm_nxt  = sm_r;
    pb_nxt  = pb_r;

    if (ph_r < ucs_pkg::PH_DONE) begin
      if (pos_r >= POS_W'(MAX_URI_LEN)) begin
        b = ucs_pkg::add_span(b, ucs_pkg::kind_of_phase(ph_r), 12'(ps_r), 13'(pos_r),
                              ucs_pkg::ERR_TOO_LONG);
        ph_nxt = ucs_pkg::PH_FAILED;
      end else begin
        unique case (ph_r)
          ucs_pkg::PH_SCHEME: begin
            if (!(ucs_pkg::is_alpha(c) || (p > ps_nxt && (ucs_pkg::is_digit(c) ||
                c == ucs_pkg::CH_PLUS || c == ucs_pkg::CH_MINUS || c == ucs_pkg::CH_DOT)))) begin
              if (c == ucs_pkg::CH_COLON && p > ps_nxt) begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_SCHEME, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_NONE);
                ph_nxt = ucs_pkg::PH_AUTH_SLASH;
                sm_nxt = 1'b0;
                ps_nxt = e;
              end else if (c == ucs_pkg::CH_SLASH && p == ps_nxt) begin
                ph_nxt = ucs_pkg::PH_PATH;
                ps_nxt = p;
              end else begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_SCHEME, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_SCHEME);
                ph_nxt = ucs_pkg::PH_FAILED;
              end
            end
          end
          ucs_pkg::PH_AUTH_SLASH: begin
            if (!sm_r) begin
              if (c == ucs_pkg::CH_SLASH) begin
                sm_nxt = 1'b1;
              end else begin
                ph_nxt  = ucs_pkg::PH_AUTHORITY;
                ps_nxt  = p;
                cc_nxt  = 2'd0;
                pb_nxt  = 1'b0;
                auth_go = 1'b1;
              end
            end else if (c == ucs_pkg::CH_SLASH) begin
              ph_nxt = ucs_pkg::PH_AUTHORITY;
              ps_nxt = e;
              cc_nxt = 2'd0;
              pb_nxt = 1'b0;
            end else begin
              b = ucs_pkg::add_span(b, ucs_pkg::KIND_HOST, 12'(p - POS_W'(1)),
                                    13'(p - POS_W'(1)), ucs_pkg::ERR_NONE);
              ph_nxt  = ucs_pkg::PH_PATH;
              ps_nxt  = p - POS_W'(1);
              path_go = 1'b1;
            end
          end
          ucs_pkg::PH_AUTHORITY: auth_go = 1'b1;
          ucs_pkg::PH_HOST: begin
            if (!ucs_pkg::is_host(c)) begin
              if (c == ucs_pkg::CH_COLON) begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_HOST, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_NONE);
                ph_nxt = ucs_pkg::PH_PORT;
                ps_nxt = e;
              end else if (c == ucs_pkg::CH_SLASH) begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_HOST, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_NONE);
                ph_nxt = ucs_pkg::PH_PATH;
                ps_nxt = p;
              end else begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_HOST, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_AUTHORITY);
                ph_nxt = ucs_pkg::PH_FAILED;
              end
            end
          end
          ucs_pkg::PH_PORT: begin
            if (!ucs_pkg::is_digit(c)) begin
              if (c == ucs_pkg::CH_SLASH && p != ps_nxt) begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_PORT, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_NONE);
                ph_nxt = ucs_pkg::PH_PATH;
                ps_nxt = p;
              end else if (c == ucs_pkg::CH_SLASH) begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_PORT, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_EMPTY_PORT);
                ph_nxt = ucs_pkg::PH_FAILED;
              end else begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_PORT, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_PORT);
                ph_nxt = ucs_pkg::PH_FAILED;
              end
            end
          end
          ucs_pkg::PH_PATH: path_go = 1'b1;
          ucs_pkg::PH_QUERY: begin
            if (!(ucs_pkg::is_pchar(c) || c == ucs_pkg::CH_SLASH ||
                  c == ucs_pkg::CH_QUEST)) begin
              if (c == ucs_pkg::CH_HASH) begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_QUERY, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_NONE);
                ph_nxt = ucs_pkg::PH_DONE;
              end else begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_QUERY, 12'(ps_nxt), 13'(p),
                                      ucs_pkg::ERR_QUERY);
                ph_nxt = ucs_pkg::PH_FAILED;
              end
            end
          end
          default: ;
        endcase

        if (auth_go) begin
          if (c == ucs_pkg::CH_AT) begin
            b = ucs_pkg::add_span(b, ucs_pkg::KIND_USERINFO, 12'(ps_nxt), 13'(p),
                                  ucs_pkg::ERR_NONE);
            ph_nxt = ucs_pkg::PH_HOST;
            ps_nxt = e;
          end else if (c == ucs_pkg::CH_COLON) begin
            if (cc_nxt == 2'd0) begin
              fcp_nxt = p;
            end else begin
              pb_nxt = 1'b1;
            end
            if (cc_nxt != 2'd2) begin
              cc_nxt = cc_nxt + 2'd1;
            end
          end else if (ucs_pkg::is_host(c)) begin
            if (cc_nxt != 2'd0 && !ucs_pkg::is_digit(c)) begin
              pb_nxt = 1'b1;
            end
          end else if (c == ucs_pkg::CH_SLASH) begin
            rs = resolve(b, cc_nxt, fcp_nxt, pb_nxt, ps_nxt, p);
            b  = rs.b;
            if (rs.ok) begin
              ph_nxt = ucs_pkg::PH_PATH;
              ps_nxt = p;
            end else begin
              ph_nxt = ucs_pkg::PH_FAILED;
            end
          end else begin
            b = ucs_pkg::add_span(b, ucs_pkg::KIND_HOST, 12'(ps_nxt), 13'(p),
                                  ucs_pkg::ERR_AUTHORITY);
            ph_nxt = ucs_pkg::PH_FAILED;
          end
        end

        if (path_go && !(ucs_pkg::is_pchar(c) || c == ucs_pkg::CH_SLASH)) begin
          if (c == ucs_pkg::CH_QUEST) begin
            b = ucs_pkg::add_span(b, ucs_pkg::KIND_PATH, 12'(ps_nxt), 13'(p),
                                  ucs_pkg::ERR_NONE);
            ph_nxt = ucs_pkg::PH_QUERY;
            ps_nxt = e;
          end else if (c == ucs_pkg::CH_HASH) begin
            b = ucs_pkg::add_span(b, ucs_pkg::KIND_PATH, 12'(ps_nxt), 13'(p),
                                  ucs_pkg::ERR_NONE);
            ph_nxt = ucs_pkg::PH_DONE;
          end else begin
            b = ucs_pkg::add_span(b, ucs_pkg::KIND_PATH, 12'(ps_nxt), 13'(p),
                                  ucs_pkg::ERR_PATH);
            ph_nxt = ucs_pkg::PH_FAILED;
          end
        end

        if (ph_nxt < ucs_pkg::PH_DONE && item.end_of_uri) begin
          unique case (ph_nxt)
            ucs_pkg::PH_SCHEME: begin
              b = ucs_pkg::add_span(b, ucs_pkg::KIND_SCHEME, 12'(ps_nxt), 13'(e),
                                    ucs_pkg::ERR_END_SCHEME);
              ph_nxt = ucs_pkg::PH_FAILED;
            end
            ucs_pkg::PH_AUTH_SLASH: begin
              b = ucs_pkg::add_span(b, ucs_pkg::KIND_HOST, 12'(ps_nxt), 13'(e),
                                    ucs_pkg::ERR_AUTH_START);
              ph_nxt = ucs_pkg::PH_FAILED;
            end
            ucs_pkg::PH_AUTHORITY: begin
              rs     = resolve(b, cc_nxt, fcp_nxt, pb_nxt, ps_nxt, e);
              b      = rs.b;
              ph_nxt = rs.ok ? ucs_pkg::PH_DONE : ucs_pkg::PH_FAILED;
            end
            ucs_pkg::PH_HOST: begin
              b = ucs_pkg::add_span(b, ucs_pkg::KIND_HOST, 12'(ps_nxt), 13'(e),
                                    ucs_pkg::ERR_NONE);
              ph_nxt = ucs_pkg::PH_DONE;
            end
            ucs_pkg::PH_PORT: begin
              if (ps_nxt == e) begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_PORT, 12'(ps_nxt), 13'(e),
                                      ucs_pkg::ERR_EMPTY_PORT);
                ph_nxt = ucs_pkg::PH_FAILED;
              end else begin
                b = ucs_pkg::add_span(b, ucs_pkg::KIND_PORT, 12'(ps_nxt), 13'(e),
                                      ucs_pkg::ERR_NONE);
                ph_nxt = ucs_pkg::PH_DONE;
              end
            end
            ucs_pkg::PH_PATH: begin
              b = ucs_pkg::add_span(b, ucs_pkg::KIND_PATH, 12'(ps_nxt), 13'(e),
                                    ucs_pkg::ERR_NONE);
              ph_nxt = ucs_pkg::PH_DONE;
            end
            ucs_pkg::PH_QUERY: begin
              b = ucs_pkg::add_span(b, ucs_pkg::KIND_QUERY, 12'(ps_nxt), 13'(e),
                                    ucs_pkg::ERR_NONE);
              ph_nxt = ucs_pkg::PH_DONE;
            end
            default: ;
          endcase
        end

        if (ph_nxt < ucs_pkg::PH_DONE) begin
          pos_nxt = e;
        end
      end
    end

    b.done = (ph_nxt >= ucs_pkg::PH_DONE);

    if (item.end_of_uri) begin
      ph_nxt  = ucs_pkg::PH_SCHEME;
      pos_nxt = '0;
      ps_nxt  = '0;
      fcp_nxt = '0;
      cc_nxt  = 2'd0;
      sm_nxt  = 1'b0;
      pb_nxt  = 1'b0;
    end

    bnd      = b;
    bnd_push = accept && (b.cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= ucs_pkg::PH_SCHEME;
      pos_r <= '0;
      ps_r  <= '0;
      fcp_r <= '0;
      cc_r  <= 2'd0;
      sm_r  <= 1'b0;
      pb_r  <= 1'b0;
    end else if (accept) begin
      ph_r  <= ph_nxt;
      pos_r <= pos_nxt;
      ps_r  <= ps_nxt;
      fcp_r <= fcp_nxt;
      cc_r  <= cc_nxt;
      sm_r  <= sm_nxt;
      pb_r  <= pb_nxt;
    end
  end

endmodule

>>> design/ucs_fifo.sv
// Short queue of span bundles between the parser front end and the result back end.
// Register array with head read in place.
// Depends on ucs_pkg.
module ucs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ucs_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             pop,
  output ucs_pkg::bundle_t rd_data,
  output logic             empty
);

  ucs_pkg::bundle_t                mem [ucs_pkg::FIFO_DEPTH];
  logic [ucs_pkg::FIFO_AW-1:0]     wr_ptr_r;
  logic [ucs_pkg::FIFO_AW-1:0]     rd_ptr_r;
  logic [ucs_pkg::FIFO_AW:0]       count_r;

  assign full    = (count_r == (ucs_pkg::FIFO_AW + 1)'(ucs_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ucs_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ucs_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (ucs_pkg::FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (ucs_pkg::FIFO_AW + 1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (wr_data.cnt != '0))
    else $error("empty bundle queued");
`endif

endmodule

>>> design/ucs_back.sv
// Back end of the URI component splitter: serializes span bundles into results.
// Holds one bundle and walks its spans, one transfer per cycle while pop is high.
// Depends on ucs_pkg.
module ucs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ucs_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             head_take,
  output ucs_pkg::out_t    out_item,
  output logic             out_empty,
  input  logic             pop
);

  ucs_pkg::bundle_t        cur_r;
  logic                    cur_v_r;
  logic [ucs_pkg::CNT_W-1:0] idx_r;
  logic                    last_item;
  logic                    xfer;
  logic                    load;
  ucs_pkg::span_t          sp;

  assign sp        = cur_r.items[idx_r];
  assign last_item = (idx_r == cur_r.cnt - ucs_pkg::CNT_W'(1));
  assign out_empty = !cur_v_r;
  assign xfer      = pop && cur_v_r;
  assign load      = !cur_v_r || (xfer && last_item);
  assign head_take = load && head_valid;

  assign out_item = '{part_kind:  sp.kind,
                      span_start: sp.start,
                      span_end:   sp.stop,
                      error_code: sp.code,
                      run_last:   last_item,
                      uri_done:   last_item && cur_r.done};

  always_ff @(posedge clk) begin
    if (head_take) begin
      cur_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      cur_v_r <= head_valid;
      idx_r   <= '0;
    end else if (xfer) begin
      idx_r <= idx_r + ucs_pkg::CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (cur_r.cnt != '0) && (idx_r < cur_r.cnt))
    else $error("span index past bundle count");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r && !pop |=> cur_v_r && $stable(idx_r) && $stable(cur_r))
    else $error("waiting result changed");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    head_take |-> head_valid)
    else $error("bundle taken from empty queue");
`endif

endmodule

>>> tb/tb_uri_component_splitter_unit.sv
// Testbench for uri_component_splitter_unit: random and directed URIs, one character per transfer,
// with a built-in parser model predicting every part span and error.
// Depends on ucs_pkg and the design files under design/.
module tb_uri_component_splitter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 4096;
  localparam int LIMIT = 2500000;

  typedef enum logic [3:0] {
    P_SCHEME, P_SLASHES, P_AUTH, P_HOST, P_PORT, P_PATH, P_QUERY, P_DONE, P_FAILED
  } parse_phase_e;

  typedef struct {
    ucs_pkg::in_t ch;
    bit           drain;
  } char_job_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          push = 1'b0;
  logic          pop = 1'b0;
  ucs_pkg::in_t  in_item = '0;
  logic          full, empty;
  ucs_pkg::out_t out_item;

  uri_component_splitter_unit #(.MAX_URI_LEN(MAX_LEN)) dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always #4 clk = ~clk;

  string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string digits = "0123456789";
  string host_marks = "-._~!$&'()*+,;=%";
  string scheme_marks = "+-.";
  string delims = ":/@?#%";

  char_job_t     chars_todo[$];
  char_job_t     job_now;
  ucs_pkg::out_t parts_due[$];
  ucs_pkg::out_t step_parts[$];
  logic [7:0]    uri_buf[$];

  bit in_fire, out_fire, offering, rx_hold;
  int tx_gap, rx_gap;
  int cycles, chars_accepted, parts_checked, errors, uri_count, rand_chars;

  parse_phase_e ph;
  int unsigned  pos, pstart, colon_at;
  int           colons, slashes;
  bit           port_junk;

  function automatic bit in_set(string s, logic [7:0] c);
    for (int i = 0; i < s.len(); i++) if (s[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit letter_ok(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return lc >= "a" && lc <= "z" && c[7] == 1'b0;
  endfunction

  function automatic bit digit_ok(logic [7:0] c);
    return in_set(digits, c);
  endfunction

  function automatic bit host_ok(logic [7:0] c);
    return letter_ok(c) || digit_ok(c) || in_set(host_marks, c);
  endfunction

  function automatic bit pchar_ok(logic [7:0] c);
    return host_ok(c) || c == ucs_pkg::CH_COLON || c == ucs_pkg::CH_AT;
  endfunction

  function automatic logic [2:0] phase_kind(parse_phase_e p);
    case (p)
      P_SCHEME: return ucs_pkg::KIND_SCHEME;
      P_SLASHES, P_AUTH, P_HOST: return ucs_pkg::KIND_HOST;
      P_PORT: return ucs_pkg::KIND_PORT;
      P_QUERY: return ucs_pkg::KIND_QUERY;
      default: return ucs_pkg::KIND_PATH;
    endcase
  endfunction

  function automatic void clear_parser();
    ph = P_SCHEME;
    pos = 0;
    pstart = 0;
    colon_at = 0;
    colons = 0;
    slashes = 0;
    port_junk = 1'b0;
  endfunction

  function automatic void add_part(logic [2:0] k, int unsigned s, int unsigned e,
                                   logic [3:0] code);
    ucs_pkg::out_t r;
    if (step_parts.size() >= ucs_pkg::N_RES) return;
    r.part_kind = k;
    r.span_start = 12'(s);
    r.span_end = 13'(e);
    r.error_code = code;
    r.run_last = 1'b0;
    r.uri_done = 1'b0;
    step_parts.push_back(r);
  endfunction

  function automatic void abort(logic [3:0] code, logic [2:0] k, int unsigned e);
    add_part(k, pstart, e, code);
    ph = P_FAILED;
  endfunction

  function automatic bit resolve_auth(int unsigned e);
    if (colons == 0) begin
      add_part(ucs_pkg::KIND_HOST, pstart, e, ucs_pkg::ERR_NONE);
      return 1'b1;
    end
    if (colon_at + 1 == e) begin
      abort(ucs_pkg::ERR_EMPTY_PORT, ucs_pkg::KIND_PORT, e);
      return 1'b0;
    end
    if (port_junk) begin
      abort(ucs_pkg::ERR_PORT, ucs_pkg::KIND_PORT, e);
      return 1'b0;
    end
    add_part(ucs_pkg::KIND_HOST, pstart, colon_at, ucs_pkg::ERR_NONE);
    add_part(ucs_pkg::KIND_PORT, colon_at + 1, e, ucs_pkg::ERR_NONE);
    return 1'b1;
  endfunction

  function automatic void open_auth(int unsigned s);
    ph = P_AUTH;
    pstart = s;
    colons = 0;
    port_junk = 1'b0;
  endfunction

  function automatic void path_step(logic [7:0] c, int unsigned p);
    if (pchar_ok(c) || c == ucs_pkg::CH_SLASH) return;
    if (c == ucs_pkg::CH_QUEST) begin
      add_part(ucs_pkg::KIND_PATH, pstart, p, ucs_pkg::ERR_NONE);
      ph = P_QUERY;
      pstart = p + 1;
    end else if (c == ucs_pkg::CH_HASH) begin
      add_part(ucs_pkg::KIND_PATH, pstart, p, ucs_pkg::ERR_NONE);
      ph = P_DONE;
    end else begin
      abort(ucs_pkg::ERR_PATH, ucs_pkg::KIND_PATH, p);
    end
  endfunction

  function automatic void auth_step(logic [7:0] c, int unsigned p);
    if (c == ucs_pkg::CH_AT) begin
      add_part(ucs_pkg::KIND_USERINFO, pstart, p, ucs_pkg::ERR_NONE);
      ph = P_HOST;
      pstart = p + 1;
    end else if (c == ucs_pkg::CH_COLON) begin
      if (colons == 0) colon_at = p;
      else port_junk = 1'b1;
      if (colons < 2) colons++;
    end else if (host_ok(c)) begin
      if (colons != 0 && !digit_ok(c)) port_junk = 1'b1;
    end else if (c == ucs_pkg::CH_SLASH) begin
      if (resolve_auth(p)) begin
        ph = P_PATH;
        pstart = p;
      end
    end else begin
      abort(ucs_pkg::ERR_AUTHORITY, ucs_pkg::KIND_HOST, p);
    end
  endfunction

  function automatic void take_char(logic [7:0] c, int unsigned p);
    case (ph)
      P_SCHEME: begin
        if (letter_ok(c) || (p > pstart && (digit_ok(c) || c == ucs_pkg::CH_PLUS ||
                                            c == ucs_pkg::CH_MINUS ||
                                            c == ucs_pkg::CH_DOT))) return;
        if (c == ucs_pkg::CH_COLON && p > pstart) begin
          add_part(ucs_pkg::KIND_SCHEME, pstart, p, ucs_pkg::ERR_NONE);
          ph = P_SLASHES;
          slashes = 0;
          pstart = p + 1;
        end else if (c == ucs_pkg::CH_SLASH && p == pstart) begin
          ph = P_PATH;
          pstart = p;
        end else begin
          abort(ucs_pkg::ERR_SCHEME, ucs_pkg::KIND_SCHEME, p);
        end
      end
      P_SLASHES: begin
        if (slashes == 0) begin
          if (c == ucs_pkg::CH_SLASH) slashes = 1;
          else begin
            open_auth(p);
            auth_step(c, p);
          end
        end else if (c == ucs_pkg::CH_SLASH) begin
          slashes = 2;
          open_auth(p + 1);
        end else begin
          add_part(ucs_pkg::KIND_HOST, p - 1, p - 1, ucs_pkg::ERR_NONE);
          ph = P_PATH;
          pstart = p - 1;
          path_step(c, p);
        end
      end
      P_AUTH: auth_step(c, p);
      P_HOST: begin
        if (host_ok(c)) return;
        if (c == ucs_pkg::CH_COLON) begin
          add_part(ucs_pkg::KIND_HOST, pstart, p, ucs_pkg::ERR_NONE);
          ph = P_PORT;
          pstart = p + 1;
        end else if (c == ucs_pkg::CH_SLASH) begin
          add_part(ucs_pkg::KIND_HOST, pstart, p, ucs_pkg::ERR_NONE);
          ph = P_PATH;
          pstart = p;
        end else begin
          abort(ucs_pkg::ERR_AUTHORITY, ucs_pkg::KIND_HOST, p);
        end
      end
      P_PORT: begin
        if (digit_ok(c)) return;
        if (c == ucs_pkg::CH_SLASH) begin
          if (p == pstart) abort(ucs_pkg::ERR_EMPTY_PORT, ucs_pkg::KIND_PORT, p);
          else begin
            add_part(ucs_pkg::KIND_PORT, pstart, p, ucs_pkg::ERR_NONE);
            ph = P_PATH;
            pstart = p;
          end
        end else begin
          abort(ucs_pkg::ERR_PORT, ucs_pkg::KIND_PORT, p);
        end
      end
      P_PATH: path_step(c, p);
      P_QUERY: begin
        if (pchar_ok(c) || c == ucs_pkg::CH_SLASH || c == ucs_pkg::CH_QUEST) return;
        if (c == ucs_pkg::CH_HASH) begin
          add_part(ucs_pkg::KIND_QUERY, pstart, p, ucs_pkg::ERR_NONE);
          ph = P_DONE;
        end else begin
          abort(ucs_pkg::ERR_QUERY, ucs_pkg::KIND_QUERY, p);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void close_uri(int unsigned e);
    case (ph)
      P_SCHEME: abort(ucs_pkg::ERR_END_SCHEME, ucs_pkg::KIND_SCHEME, e);
      P_SLASHES: abort(ucs_pkg::ERR_AUTH_START, ucs_pkg::KIND_HOST, e);
      P_AUTH: if (resolve_auth(e)) ph = P_DONE;
      P_HOST: begin
        add_part(ucs_pkg::KIND_HOST, pstart, e, ucs_pkg::ERR_NONE);
        ph = P_DONE;
      end
      P_PORT: begin
        if (pstart == e) abort(ucs_pkg::ERR_EMPTY_PORT, ucs_pkg::KIND_PORT, e);
        else begin
          add_part(ucs_pkg::KIND_PORT, pstart, e, ucs_pkg::ERR_NONE);
          ph = P_DONE;
        end
      end
      P_PATH: begin
        add_part(ucs_pkg::KIND_PATH, pstart, e, ucs_pkg::ERR_NONE);
        ph = P_DONE;
      end
      P_QUERY: begin
        add_part(ucs_pkg::KIND_QUERY, pstart, e, ucs_pkg::ERR_NONE);
        ph = P_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic void split_char(ucs_pkg::in_t it);
    ucs_pkg::out_t r;
    int            n;
    step_parts.delete();
    if (ph < P_DONE) begin
      if (pos >= MAX_LEN) abort(ucs_pkg::ERR_TOO_LONG, phase_kind(ph), pos);
      else begin
        take_char(it.char_code, pos);
        if (ph < P_DONE && it.end_of_uri) close_uri(pos + 1);
        if (ph < P_DONE) pos++;
      end
    end
    n = step_parts.size();
    if (n > 0) begin
      r = step_parts[n - 1];
      r.run_last = 1'b1;
      r.uri_done = (ph >= P_DONE);
      step_parts[n - 1] = r;
    end
    foreach (step_parts[i]) parts_due.push_back(step_parts[i]);
    if (it.end_of_uri) clear_parser();
  endfunction

  function automatic void check_part(ucs_pkg::out_t got);
    ucs_pkg::out_t want;
    if (parts_due.size() == 0) begin
      if (errors < 10)
        $display("unexpected part at cycle %0d: kind %0d span %0d..%0d err %0d", cycles,
                 got.part_kind, got.span_start, got.span_end, got.error_code);
      errors++;
      return;
    end
    want = parts_due.pop_front();
    parts_checked++;
    if (got.part_kind !== want.part_kind || got.span_start !== want.span_start ||
        got.span_end !== want.span_end || got.error_code !== want.error_code ||
        got.run_last !== want.run_last || got.uri_done !== want.uri_done) begin
      if (errors < 10) begin
        $display("mismatch at cycle %0d", cycles);
        $display("  expected kind %0d span %0d..%0d err %0d last %0b done %0b",
                 want.part_kind, want.span_start, want.span_end, want.error_code,
                 want.run_last, want.uri_done);
        $display("  actual   kind %0d span %0d..%0d err %0d last %0b done %0b",
                 got.part_kind, got.span_start, got.span_end, got.error_code,
                 got.run_last, got.uri_done);
      end
      errors++;
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] host_pick();
    case ($urandom_range(0, 3))
      0, 1: return pick(letters);
      2: return pick(digits);
      default: return pick(host_marks);
    endcase
  endfunction

  function automatic logic [7:0] pchar_pick();
    if ($urandom_range(0, 9) == 0) return pick(":@");
    return host_pick();
  endfunction

  function automatic logic [7:0] scheme_pick();
    case ($urandom_range(0, 3))
      0, 1: return pick(letters);
      2: return pick(digits);
      default: return pick(scheme_marks);
    endcase
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) uri_buf.push_back(s[i]);
  endtask

  task automatic flush_uri(bit drain);
    char_job_t job;
    foreach (uri_buf[i]) begin
      job.ch.char_code = uri_buf[i];
      job.ch.end_of_uri = (i == uri_buf.size() - 1);
      job.drain = drain && i == 0;
      chars_todo.push_back(job);
    end
    uri_buf.delete();
    uri_count++;
  endtask

  task automatic add_authority();
    if ($urandom_range(0, 9) < 4) begin
      repeat ($urandom_range(0, 4))
        uri_buf.push_back($urandom_range(0, 5) == 0 ? ucs_pkg::CH_COLON : host_pick());
      uri_buf.push_back(ucs_pkg::CH_AT);
    end
    repeat ($urandom_range(0, 5)) uri_buf.push_back(host_pick());
    if ($urandom_range(0, 9) < 4) begin
      uri_buf.push_back(ucs_pkg::CH_COLON);
      repeat ($urandom_range(0, 4))
        uri_buf.push_back($urandom_range(0, 7) == 0 ? host_pick() : pick(digits));
    end
  endtask

  task automatic gen_uri();
    int shape, mode;
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 8)) uri_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (shape < 20) begin
        uri_buf.push_back(ucs_pkg::CH_SLASH);
        repeat ($urandom_range(0, 4)) uri_buf.push_back(pchar_pick());
      end else begin
        uri_buf.push_back(pick(letters));
        repeat ($urandom_range(0, 4)) uri_buf.push_back(scheme_pick());
        uri_buf.push_back(ucs_pkg::CH_COLON);
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          put_text("//");
          add_authority();
        end else if (mode < 8) begin
          add_authority();
        end else if (mode == 8) begin
          uri_buf.push_back(ucs_pkg::CH_SLASH);
          uri_buf.push_back(pchar_pick());
        end
      end
      repeat ($urandom_range(0, 3)) begin
        uri_buf.push_back(ucs_pkg::CH_SLASH);
        repeat ($urandom_range(0, 4)) uri_buf.push_back(pchar_pick());
      end
      if ($urandom_range(0, 9) < 3) begin
        uri_buf.push_back(ucs_pkg::CH_QUEST);
        repeat ($urandom_range(0, 5))
          uri_buf.push_back($urandom_range(0, 5) == 0 ? pick("/?") : pchar_pick());
      end
      if ($urandom_range(0, 9) < 2) begin
        uri_buf.push_back(ucs_pkg::CH_HASH);
        repeat ($urandom_range(0, 3)) uri_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (shape >= 80)
        uri_buf[$urandom_range(0, uri_buf.size() - 1)] =
          $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick(delims);
    end
  endtask

  always @(posedge clk) begin
    in_fire = rst_n && push && !full;
    out_fire = rst_n && pop && !empty;
    cycles++;
    if (in_fire) begin
      split_char(in_item);
      chars_accepted++;
    end
    if (out_fire) check_part(out_item);
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        offering = 1'b0;
        tx_gap = rx_hold ? 0 : gap_len();
      end
      if (!offering) begin
        if (tx_gap > 0) tx_gap--;
        else if (chars_todo.size() != 0 &&
                 !(chars_todo[0].drain && parts_due.size() != 0)) begin
          job_now = chars_todo.pop_front();
          offering = 1'b1;
        end
      end
      push <= offering;
      in_item <= job_now.ch;
    end
  end

  always @(negedge clk) begin
    if (out_fire) rx_gap = gap_len();
    if (!rst_n || rx_hold) pop <= 1'b0;
    else if (rx_gap > 0) begin
      rx_gap--;
      pop <= 1'b0;
    end else pop <= 1'b1;
  end

  // hold off the output long enough for the internal queue to fill and stall input
  initial begin
    while (chars_accepted < 60) @(posedge clk);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    while (cycles < LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d parts still due", cycles, parts_due.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    clear_parser();
    put_text("/");
    flush_uri(1'b0);
    put_text("a:/b");
    flush_uri(1'b0);
    put_text("a:/?");
    flush_uri(1'b0);
    put_text("a:#");
    flush_uri(1'b0);
    put_text("ab");
    flush_uri(1'b0);
    uri_buf.push_back(8'h00);
    flush_uri(1'b0);
    uri_buf.push_back(8'hFF);
    flush_uri(1'b0);
    put_text("x:h:");
    flush_uri(1'b0);
    put_text("s://u@h:8/p?q#z");
    flush_uri(1'b0);
    while (rand_chars < 390) begin
      gen_uri();
      rand_chars += uri_buf.size();
      flush_uri(uri_count == 20 || uri_count == 40);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (chars_todo.size() != 0 || offering || parts_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d URIs in %0d characters, %0d parts checked, %0d mismatches",
             uri_count, chars_accepted, parts_checked, errors);
    $display("runs included a long output stall that filled the queue and sender pauses");
    if (errors == 0 && parts_due.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
